// ===== rtl/core/ssched_pkg.sv =====
// Shared types and constants for the SSTF disk request scheduler.
// No dependencies; imported by every module of the block except ssched_ram.
package ssched_pkg;

  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned MaxRequesters = 64;
  localparam int unsigned TrackBits     = 16;
  localparam int unsigned RqBits        = 6;
  localparam int unsigned LimitBits     = 4;
  localparam int unsigned CountBits     = 7;
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned CfgDataBits   = 8;

  localparam logic [LimitBits-1:0] LimitReset = LimitBits'(3);
  localparam logic [CountBits-1:0] CountReset = CountBits'(5);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_QUEUE_LIMIT = 2'd0,
    CFG_REQ_COUNT   = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_SERVICED  = 2'd0,
    STATUS_DUPLICATE = 2'd1,
    STATUS_NO_ACTIVE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUP_SCAN,
    ST_INSERT,
    ST_DRAIN_CHECK,
    ST_SRV_SCAN,
    ST_EMIT,
    ST_REJECT
  } ssched_state_e;

  typedef struct packed {
    logic [RqBits-1:0]    requester;
    logic [TrackBits-1:0] track;
    logic                 final_request;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [RqBits-1:0]    served_requester;
    logic [TrackBits-1:0] served_track;
    logic                 run_end;
  } rsp_t;

  // One pending-table entry as held in the RAM.
  typedef struct packed {
    logic [RqBits-1:0]    requester;
    logic [TrackBits-1:0] track;
  } entry_t;

  // Sweep control from the sequencer to the nearest-entry picker.
  typedef struct packed {
    logic                 start;
    logic                 chk;
    logic                 entry_valid;
    logic                 mode_srv;
    logic [RqBits-1:0]    requester;
    logic [TrackBits-1:0] head;
  } scan_ctl_t;

  // Picker outcome after a sweep.
  typedef struct packed {
    logic                 hit;
    logic [RqBits-1:0]    requester;
    logic [TrackBits-1:0] track;
  } pick_res_t;

endpackage

// ===== rtl/core/ssched_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ssched_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ssched_pick.sv =====
// Sweep datapath: duplicate-requester match and nearest-track selection.
// Depends on ssched_pkg; fed one RAM entry per cycle by ssched_ctrl.
module ssched_pick import ssched_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef,
  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scan_ctl_t       ctl_i,
  input  logic [IdxW-1:0] chk_idx_i,
  input  entry_t          entry_i,
  output pick_res_t       res_o,
  output logic [IdxW-1:0] best_idx_o
);

  logic                 hit_q, hit_d;
  logic [IdxW-1:0]      best_idx_q, best_idx_d;
  logic [RqBits-1:0]    best_rq_q, best_rq_d;
  logic [TrackBits-1:0] best_trk_q, best_trk_d;
  logic [TrackBits-1:0] best_dist_q, best_dist_d;
  logic [TrackBits-1:0] seek_dist;
  logic                 better;

  always_comb begin
    seek_dist = (entry_i.track > ctl_i.head) ? (entry_i.track - ctl_i.head)
                                             : (ctl_i.head - entry_i.track);
    better = !hit_q || (seek_dist < best_dist_q) ||
             ((seek_dist == best_dist_q) && (entry_i.requester < best_rq_q));

    hit_d       = hit_q;
    best_idx_d  = best_idx_q;
    best_rq_d   = best_rq_q;
    best_trk_d  = best_trk_q;
    best_dist_d = best_dist_q;

    if (ctl_i.start) begin
      hit_d = 1'b0;
    end else if (ctl_i.chk && ctl_i.entry_valid) begin
      if (!ctl_i.mode_srv) begin
        if (entry_i.requester == ctl_i.requester) begin
          hit_d = 1'b1;
        end
      end else if (better) begin
        hit_d       = 1'b1;
        best_idx_d  = chk_idx_i;
        best_rq_d   = entry_i.requester;
        best_trk_d  = entry_i.track;
        best_dist_d = seek_dist;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_rq_q   <= best_rq_d;
    best_trk_q  <= best_trk_d;
    best_dist_q <= best_dist_d;
  end

  assign res_o.hit       = hit_q;
  assign res_o.requester = best_rq_q;
  assign res_o.track     = best_trk_q;
  assign best_idx_o      = best_idx_q;

endmodule

// ===== rtl/core/ssched_ctrl.sv =====
// Sequencer: handshakes, config registers, valid bits, head, sweeps, result register.
// Depends on ssched_pkg; drives ssched_ram and ssched_pick.
module ssched_ctrl import ssched_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef,
  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1,
  localparam int unsigned OccW = $clog2(QueueDepth + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  req_t                   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rsp_t                   out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output logic                   ram_we_o,
  output logic [IdxW-1:0]        ram_waddr_o,
  output entry_t                 ram_wdata_o,
  output logic                   ram_re_o,
  output logic [IdxW-1:0]        ram_raddr_o,
  output scan_ctl_t              scan_o,
  output logic [IdxW-1:0]        chk_idx_o,
  input  pick_res_t              pick_i,
  input  logic [IdxW-1:0]        pick_idx_i
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);

  ssched_state_e         state_q, state_d;
  logic [QueueDepth-1:0] valid_q, valid_d;
  logic [OccW-1:0]       occ_q, occ_d;
  logic [TrackBits-1:0]  head_q, head_d;
  logic [CountBits-1:0]  active_q, active_d;
  logic [LimitBits-1:0]  limit_q, limit_d;
  req_t                  req_q, req_d;
  status_e               rej_q, rej_d;
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic                  issue_q, issue_d;
  logic                  chk_q, chk_d;
  logic [IdxW-1:0]       chk_idx_q, chk_idx_d;
  rsp_t                  out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  free_found;
  logic [IdxW-1:0]       free_idx;
  logic [OccW-1:0]       lim_eff, target, occ_m1;
  logic                  scanning, sweep_done, scan_start, out_free, run_end;
  logic [CountBits-1:0]  cnt_sat;

  // first free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    lim_eff = (32'(limit_q) > 32'(QueueDepth)) ? OccW'(QueueDepth) : OccW'(limit_q);
    target  = (32'(active_q) < 32'(lim_eff)) ? OccW'(active_q) : lim_eff;
    occ_m1  = occ_q - OccW'(1);
    run_end = (occ_m1 == '0) || (occ_m1 < target);
    cnt_sat = (32'(cfg_data_i[CountBits-1:0]) > 32'(MaxRequesters)) ?
              CountBits'(MaxRequesters) : cfg_data_i[CountBits-1:0];
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    occ_d       = occ_q;
    head_d      = head_q;
    active_d    = active_q;
    limit_d     = limit_q;
    req_d       = req_q;
    rej_d       = rej_q;
    rd_idx_d    = rd_idx_q;
    issue_d     = issue_q;
    out_d       = out_q;
    scan_start  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = free_idx;
    ram_wdata_o = '{requester: req_q.requester, track: req_q.track};

    scanning   = (state_q == ST_DUP_SCAN) || (state_q == ST_SRV_SCAN);
    sweep_done = chk_q && (chk_idx_q == LastIdx);
    out_free   = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o = (state_q == ST_IDLE);

    // one RAM read issued per sweep cycle, checked in the following cycle
    ram_re_o    = scanning && issue_q;
    ram_raddr_o = rd_idx_q;
    chk_d       = ram_re_o;
    chk_idx_d   = rd_idx_q;
    if (ram_re_o) begin
      if (rd_idx_q == LastIdx) begin
        issue_d = 1'b0;
      end else begin
        rd_idx_d = rd_idx_q + IdxW'(1);
      end
    end

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_QUEUE_LIMIT) begin
        limit_d = cfg_data_i[LimitBits-1:0];
      end else if (cfg_index_i == CFG_REQ_COUNT) begin
        active_d = cnt_sat;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          if (active_q == '0) begin
            rej_d   = STATUS_NO_ACTIVE;
            state_d = ST_REJECT;
          end else begin
            scan_start = 1'b1;
            state_d    = ST_DUP_SCAN;
          end
        end
      end
      ST_DUP_SCAN: begin
        if (sweep_done) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (pick_i.hit || !free_found) begin
          rej_d   = STATUS_DUPLICATE;
          state_d = ST_REJECT;
        end else begin
          ram_we_o          = 1'b1;
          valid_d[free_idx] = 1'b1;
          occ_d             = occ_q + OccW'(1);
          if (req_q.final_request) begin
            active_d = active_q - CountBits'(1);
          end
          state_d = ST_DRAIN_CHECK;
        end
      end
      ST_DRAIN_CHECK: begin
        if ((occ_q != '0) && (occ_q >= target)) begin
          scan_start = 1'b1;
          state_d    = ST_SRV_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SRV_SCAN: begin
        if (sweep_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.status            = STATUS_SERVICED;
          out_d.served_requester  = pick_i.requester;
          out_d.served_track      = pick_i.track;
          out_d.run_end           = run_end;
          head_d                  = pick_i.track;
          valid_d[pick_idx_i]     = 1'b0;
          occ_d                   = occ_m1;
          if (run_end) begin
            state_d = ST_IDLE;
          end else begin
            scan_start = 1'b1;
            state_d    = ST_SRV_SCAN;
          end
        end
      end
      ST_REJECT: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.status           = rej_q;
          out_d.served_requester = req_q.requester;
          out_d.served_track     = head_q;
          out_d.run_end          = 1'b1;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (scan_start) begin
      rd_idx_d = '0;
      issue_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      occ_q       <= '0;
      head_q      <= '0;
      active_q    <= CountReset;
      limit_q     <= LimitReset;
      issue_q     <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      head_q      <= head_d;
      active_q    <= active_d;
      limit_q     <= limit_d;
      issue_q     <= issue_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rej_q     <= rej_d;
    rd_idx_q  <= rd_idx_d;
    chk_idx_q <= chk_idx_d;
    out_q     <= out_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign scan_o.start       = scan_start;
  assign scan_o.chk         = chk_q;
  assign scan_o.entry_valid = valid_q[chk_idx_q];
  assign scan_o.mode_srv    = (state_q == ST_SRV_SCAN);
  assign scan_o.requester   = req_q.requester;
  assign scan_o.head        = head_q;
  assign chk_idx_o          = chk_idx_q;

endmodule

// ===== rtl/core/sstf_disk_request_scheduler.sv =====
// Top level of the shortest-seek-time-first disk request scheduler.
// Depends on ssched_pkg, ssched_ram, ssched_pick and ssched_ctrl.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | sink      | in_valid_i / in_ready_o  | in_data_i  (req_t)
//   out     | source    | out_valid_o / out_ready_i| out_data_o (rsp_t)
//   cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One request is worked at a time. A request with no active requesters goes
// straight to the reject step and the result register. Otherwise a duplicate
// sweep over the entry RAM (D = QueueDepth entries), one read per cycle, is
// followed by the insert and drain-check steps. Each serviced entry costs
// another sweep plus an emit step; the single RAM read port makes each sweep
// read the entries one at a time.
// Reset clears the valid bits, head, occupancy and loads queue_limit = 3 and
// active requesters = 5; the RAM is not cleared, as only valid entries are used.
// A stalled output only holds the sequencer at the emit or reject step; the input
// is taken again as soon as the sequencer is idle, with a result still waiting.
// cfg_ready_o is tied high and a write lands at once; writes are to be issued only
// while the block is idle, which the user must keep to, as the block does not enforce it.
module sstf_disk_request_scheduler import ssched_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  req_t                   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rsp_t                   out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  // sequencer <-> entry RAM
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;

  // sequencer <-> picker
  scan_ctl_t       scan;
  logic [IdxW-1:0] chk_idx, pick_idx;
  pick_res_t       pick;

  ssched_ram #(
    .Width ($bits(entry_t)),
    .Depth (QueueDepth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ssched_pick #(
    .QueueDepth (QueueDepth)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan),
    .chk_idx_i  (chk_idx),
    .entry_i    (ram_rdata),
    .res_o      (pick),
    .best_idx_o (pick_idx)
  );

  ssched_ctrl #(
    .QueueDepth (QueueDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .scan_o      (scan),
    .chk_idx_o   (chk_idx),
    .pick_i      (pick),
    .pick_idx_i  (pick_idx)
  );

endmodule

// ===== rtl/core/ssched_checker.sv =====
// Port-level checks for the SSTF scheduler, bound to the top level.
// Depends on ssched_pkg and sstf_disk_request_scheduler.
module ssched_checker import ssched_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input req_t                   in_data_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input rsp_t                   out_data_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [CfgIdxBits-1:0]  cfg_index_i,
  input logic [CfgDataBits-1:0] cfg_data_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // rejections always close their transaction
  a_reject_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_SERVICED) |-> out_data_o.run_end)
    else $error("rejection without run_end");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STATUS_SERVICED) ||
                    (out_data_o.status == STATUS_DUPLICATE) ||
                    (out_data_o.status == STATUS_NO_ACTIVE))
    else $error("undefined status code");

  // one request in flight: input closes after each accepted transaction
  a_in_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in work");

endmodule

bind sstf_disk_request_scheduler ssched_checker u_ssched_checker (.*);
